// ----- hdl/imu_pkg.sv -----
// Shared types, constants and register codes of the IMU packet integrator.
`default_nettype none
package imu_pkg;

  // Window and header geometry
  localparam int WinDepth = 14;
  localparam int WinIdxW  = 4;

  // Configuration register indexes and reset values
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_TIME_STEP     = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_HEADER_FIRST  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_HEADER_SECOND = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_HEADER_THIRD  = 2'd3;

  localparam logic [31:0] TIME_STEP_RST = 32'h3CCC_CCCD;
  localparam logic [7:0]  HDR_FIRST_RST  = 8'h40;
  localparam logic [7:0]  HDR_SECOND_RST = 8'h30;
  localparam logic [7:0]  HDR_THIRD_RST  = 8'h0C;

  localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

  // Float unit operation codes
  localparam logic FPU_MUL = 1'b0;
  localparam logic FPU_ADD = 1'b1;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] data_byte;
    logic       end_of_message;
  } imu_item_t;

  typedef struct packed {
    logic        packet_found;
    logic [31:0] accel_x;
    logic [31:0] accel_y;
    logic [31:0] accel_z;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic [31:0] vel_z;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
  } imu_result_t;

  typedef struct packed {
    logic       push;
    logic       clear;
    logic [7:0] data;
  } win_ctl_t;

  typedef struct packed {
    logic        match;
    logic [31:0] word0;
    logic [31:0] word1;
    logic [31:0] word2;
  } win_stat_t;

  typedef struct packed {
    logic        start;
    logic        op;
    logic [31:0] a;
    logic [31:0] b;
  } fpu_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] res;
  } fpu_rsp_t;

endpackage
`default_nettype wire

// ----- hdl/imu_item_if.sv -----
// Input channel interface carrying one message byte item.
`default_nettype none
interface imu_item_if;
  logic                valid;
  logic                ready;
  imu_pkg::imu_item_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- hdl/imu_result_if.sv -----
// Result channel interface carrying the integrator state snapshot.
`default_nettype none
interface imu_result_if;
  logic                 valid;
  logic                 ready;
  imu_pkg::imu_result_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- hdl/imu_window.sv -----
// Sliding byte window with header match and payload word extraction.
`default_nettype none
module imu_window (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire imu_pkg::win_ctl_t ctl,
  input  wire logic [7:0]        hdr_first,
  input  wire logic [7:0]        hdr_second,
  input  wire logic [7:0]        hdr_third,
  output imu_pkg::win_stat_t     stat
);

  logic [7:0]                  win_r [imu_pkg::WinDepth];
  logic [imu_pkg::WinIdxW-1:0] fill_r;
  logic                        full;

  assign full = (fill_r == imu_pkg::WinIdxW'(imu_pkg::WinDepth));

  // Match the header and assemble the big-endian words with the incoming byte
  always_comb begin
    stat.match = full && (win_r[0] == hdr_first) && (win_r[1] == hdr_second)
                 && (win_r[2] == hdr_third);
    stat.word0 = {win_r[3], win_r[4], win_r[5], win_r[6]};
    stat.word1 = {win_r[7], win_r[8], win_r[9], win_r[10]};
    stat.word2 = {win_r[11], win_r[12], win_r[13], ctl.data};
  end

  // Fill level: clear at message end, count up until full
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (ctl.clear) begin
      fill_r <= '0;
    end else if (ctl.push && !full) begin
      fill_r <= fill_r + 1'b1;
    end
  end

  // Window contents: append while filling, shift once full
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      if (!full) begin
        win_r[fill_r] <= ctl.data;
      end else begin
        for (int i = 0; i < imu_pkg::WinDepth - 1; i++) begin
          win_r[i] <= win_r[i+1];
        end
        win_r[imu_pkg::WinDepth-1] <= ctl.data;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/imu_fpu.sv -----
// Shared single-precision multiply/add unit with iterative normalization.
`default_nettype none
module imu_fpu (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire imu_pkg::fpu_req_t req,
  output imu_pkg::fpu_rsp_t      rsp
);

  localparam int MW   = 51;
  localparam int FRAC = MW - 24;

  localparam logic signed [11:0] EMIN     = -12'sd149;
  localparam logic signed [11:0] EBIAS    = 12'sd150;
  localparam logic signed [11:0] EFRAC    = 12'(FRAC);
  localparam logic signed [11:0] EADD_OFS = 12'sd26;

  typedef enum logic [1:0] {S_IDLE, S_NORM, S_FIN} fpu_state_t;

  fpu_state_t        state_r;
  logic [MW-1:0]     m_r;
  logic signed [11:0] e_r;
  logic              s_r;
  logic              done_r;
  logic [31:0]       res_r;

  // Operand unpacking
  logic              a_nan, a_inf, a_zero, b_nan, b_inf, b_zero;
  logic [23:0]       a_m, b_m;
  logic signed [11:0] a_e, b_e;

  always_comb begin
    a_nan  = (req.a[30:23] == 8'hFF) && (req.a[22:0] != '0);
    a_inf  = (req.a[30:23] == 8'hFF) && (req.a[22:0] == '0);
    a_zero = (req.a[30:0] == '0);
    b_nan  = (req.b[30:23] == 8'hFF) && (req.b[22:0] != '0);
    b_inf  = (req.b[30:23] == 8'hFF) && (req.b[22:0] == '0);
    b_zero = (req.b[30:0] == '0);
    a_m    = {req.a[30:23] != 8'h00, req.a[22:0]};
    b_m    = {req.b[30:23] != 8'h00, req.b[22:0]};
    a_e    = $signed({4'b0, (req.a[30:23] == 8'h00) ? 8'h01 : req.a[30:23]}) - EBIAS;
    b_e    = $signed({4'b0, (req.b[30:23] == 8'h00) ? 8'h01 : req.b[30:23]}) - EBIAS;
  end

  // Start cycle: special cases, product, or aligned sum
  logic              st_special;
  logic [31:0]       st_special_res;
  logic [MW-1:0]     st_m;
  logic signed [11:0] st_e;
  logic              st_s;

  always_comb begin
    logic              swap, sub, lost;
    logic [31:0]       x, y;
    logic [23:0]       x_m, y_m;
    logic signed [11:0] x_e, y_e, d;
    logic [MW-1:0]     xf, yf, ysh;
    logic [47:0]       prod;
    swap = 1'b0; sub = 1'b0; lost = 1'b0;
    x = req.a; y = req.b; x_m = a_m; y_m = b_m; x_e = a_e; y_e = b_e;
    d = '0; xf = '0; yf = '0; ysh = '0; prod = '0;
    st_special     = 1'b0;
    st_special_res = imu_pkg::CANON_NAN;
    st_m           = '0;
    st_e           = '0;
    st_s           = 1'b0;
    if (req.op == imu_pkg::FPU_MUL) begin
      if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
        st_special = 1'b1;
      end else if (a_inf || b_inf) begin
        st_special     = 1'b1;
        st_special_res = {req.a[31] ^ req.b[31], 8'hFF, 23'h0};
      end
      prod = a_m * b_m;
      st_m = {{(MW-48){1'b0}}, prod};
      st_e = a_e + b_e;
      st_s = req.a[31] ^ req.b[31];
    end else begin
      if (a_nan || b_nan || (a_inf && b_inf && (req.a[31] != req.b[31]))) begin
        st_special = 1'b1;
      end else if (a_inf) begin
        st_special     = 1'b1;
        st_special_res = req.a;
      end else if (b_inf) begin
        st_special     = 1'b1;
        st_special_res = req.b;
      end
      // Larger magnitude goes first
      swap = (req.b[30:0] > req.a[30:0]);
      if (swap) begin
        x = req.b; y = req.a; x_m = b_m; y_m = a_m; x_e = b_e; y_e = a_e;
      end
      sub  = x[31] ^ y[31];
      d    = x_e - y_e;
      xf   = {1'b0, x_m, 26'b0};
      yf   = {1'b0, y_m, 26'b0};
      ysh  = yf >> $unsigned(d);
      lost = ((ysh << $unsigned(d)) != yf);
      ysh  = ysh | {{(MW-1){1'b0}}, lost};
      st_m = sub ? (xf - ysh) : (xf + ysh);
      st_e = x_e - EADD_OFS;
      st_s = (sub && (st_m == '0)) ? 1'b0 : x[31];
    end
  end

  // Normalization step decisions
  logic signed [11:0] eb;
  logic               shift8, shift1;

  always_comb begin
    eb     = e_r + EFRAC;
    shift8 = (m_r[MW-1:MW-8] == '0) && ((eb - 12'sd8) >= EMIN);
    shift1 = !m_r[MW-1] && (eb > EMIN);
  end

  // Final denormalizing shift and round to nearest even
  logic [31:0] fin_res;

  always_comb begin
    logic signed [11:0] dsh, ebf, exp_c;
    logic [MW-1:0]      msh;
    logic               stk, g, inc;
    logic [23:0]        sig;
    logic [24:0]        sig_r;
    logic [23:0]        sig_f;
    dsh = '0; ebf = eb; msh = m_r; stk = 1'b0;
    if (eb < EMIN) begin
      dsh = EMIN - eb;
      ebf = EMIN;
      if ($unsigned(dsh) >= 12'(MW)) begin
        msh = '0;
        stk = (m_r != '0);
      end else begin
        msh = m_r >> dsh[5:0];
        stk = ((msh << dsh[5:0]) != m_r);
      end
    end
    sig   = msh[MW-1:FRAC];
    g     = msh[FRAC-1];
    stk   = stk | (msh[FRAC-2:0] != '0);
    inc   = g & (stk | sig[0]);
    sig_r = {1'b0, sig} + {24'b0, inc};
    if (sig_r[24]) begin
      sig_f = sig_r[24:1];
      ebf   = ebf + 12'sd1;
    end else begin
      sig_f = sig_r[23:0];
    end
    exp_c = ebf + EBIAS;
    if (!sig_f[23]) begin
      fin_res = {s_r, 8'h00, sig_f[22:0]};
    end else if (exp_c >= 12'sd255) begin
      fin_res = {s_r, 8'hFF, 23'h0};
    end else begin
      fin_res = {s_r, exp_c[7:0], sig_f[22:0]};
    end
  end

  // Sequencer: load, normalize, round
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (req.start) begin
            if (st_special) begin
              res_r  <= st_special_res;
              done_r <= 1'b1;
            end else begin
              m_r     <= st_m;
              e_r     <= st_e;
              s_r     <= st_s;
              state_r <= S_NORM;
            end
          end
        end
        S_NORM: begin
          if (m_r == '0) begin
            state_r <= S_FIN;
          end else if (shift8) begin
            m_r <= {m_r[MW-9:0], 8'b0};
            e_r <= e_r - 12'sd8;
          end else if (shift1) begin
            m_r <= {m_r[MW-2:0], 1'b0};
            e_r <= e_r - 12'sd1;
          end else begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          res_r   <= fin_res;
          done_r  <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.res  = res_r;

endmodule
`default_nettype wire

// ----- hdl/imu_packet_sync_integrator_top.sv -----
// Top level: packet sync, register file and float integration sequencer.
//
//  channel | dir | handshake          | payload
//  in_s    | in  | valid/ready        | byte_valid, data_byte, end_of_message
//  out_s   | out | valid/ready        | packet_found, accel, vel, pos (x/y/z)
//  cfg_*   | in  | cfg_we, no stall   | cfg_index, cfg_data
//
// A found packet adds three multiply/add pairs for velocity, a message end three
// more for position; all run on the one shared float unit. An operation
// normalizes by shifts of eight or one bit, and skips normalization when an
// operand is NaN or infinite.
// Synchronous active-low reset restores the register defaults and zero state.
// in_s.ready is high only while idle and out of reset; a result waiting on
// out_s stalls the sequencer only at the point where the next result is loaded.
`default_nettype none
module imu_packet_sync_integrator_top (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  imu_item_if.sink                          in_s,
  imu_result_if.source                      out_s,
  input  wire logic                         cfg_we,
  input  wire logic [imu_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [31:0]                  cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_MUL, S_MULW, S_ADD, S_ADDW, S_EMIT
  } seq_state_t;

  seq_state_t           state_r;
  imu_pkg::imu_item_t   item_r;
  logic [31:0]          ts_r;
  logic [7:0]           hf_r, hs_r, ht_r;
  logic [31:0]          accel_r [3];
  logic [31:0]          vel_r   [3];
  logic [31:0]          pos_r   [3];
  logic [31:0]          prod_r;
  logic                 found_r;
  logic                 pos_phase_r;
  logic [1:0]           k_r;
  logic                 out_valid_r;
  imu_pkg::imu_result_t out_data_r;

  imu_pkg::win_ctl_t    win_ctl;
  imu_pkg::win_stat_t   win_stat;
  imu_pkg::fpu_req_t    fpu_req;
  imu_pkg::fpu_rsp_t    fpu_rsp;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r <= imu_pkg::TIME_STEP_RST;
      hf_r <= imu_pkg::HDR_FIRST_RST;
      hs_r <= imu_pkg::HDR_SECOND_RST;
      ht_r <= imu_pkg::HDR_THIRD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        imu_pkg::CFG_TIME_STEP:     ts_r <= cfg_data;
        imu_pkg::CFG_HEADER_FIRST:  hf_r <= cfg_data[7:0];
        imu_pkg::CFG_HEADER_SECOND: hs_r <= cfg_data[7:0];
        imu_pkg::CFG_HEADER_THIRD:  ht_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Window update happens in the check cycle; a message end clears it
  always_comb begin
    win_ctl.push  = (state_r == S_CHECK) && item_r.byte_valid;
    win_ctl.clear = (state_r == S_CHECK) && item_r.end_of_message;
    win_ctl.data  = item_r.data_byte;
  end

  imu_window u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (win_ctl),
    .hdr_first  (hf_r),
    .hdr_second (hs_r),
    .hdr_third  (ht_r),
    .stat       (win_stat)
  );

  // Float operand selection: velocity phase, then position phase
  always_comb begin
    fpu_req.start = (state_r == S_MUL) || (state_r == S_ADD);
    fpu_req.op    = (state_r == S_ADD) ? imu_pkg::FPU_ADD : imu_pkg::FPU_MUL;
    if (state_r == S_ADD) begin
      fpu_req.a = pos_phase_r ? pos_r[k_r] : vel_r[k_r];
      fpu_req.b = prod_r;
    end else begin
      fpu_req.a = pos_phase_r ? vel_r[k_r] : accel_r[k_r];
      fpu_req.b = ts_r;
    end
  end

  imu_fpu u_fpu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (fpu_req),
    .rsp   (fpu_rsp)
  );

  // Sequencer, state stores and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      pos_phase_r <= 1'b0;
      k_r         <= '0;
      for (int i = 0; i < 3; i++) begin
        accel_r[i] <= '0;
        vel_r[i]   <= '0;
        pos_r[i]   <= '0;
      end
    end else begin
      // Drop the result once transferred, unless a new one loads now
      if (out_valid_r && out_s.ready && (state_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_s.valid) begin
            item_r  <= in_s.payload;
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          found_r <= item_r.byte_valid && win_stat.match;
          k_r     <= '0;
          if (item_r.byte_valid && win_stat.match) begin
            accel_r[0]  <= win_stat.word0;
            accel_r[1]  <= win_stat.word1;
            accel_r[2]  <= win_stat.word2;
            pos_phase_r <= 1'b0;
            state_r     <= S_MUL;
          end else if (item_r.end_of_message) begin
            pos_phase_r <= 1'b1;
            state_r     <= S_MUL;
          end else begin
            state_r <= S_EMIT;
          end
        end
        S_MUL: state_r <= S_MULW;
        S_MULW: begin
          if (fpu_rsp.done) begin
            prod_r  <= fpu_rsp.res;
            state_r <= S_ADD;
          end
        end
        S_ADD: state_r <= S_ADDW;
        S_ADDW: begin
          if (fpu_rsp.done) begin
            if (pos_phase_r) begin
              pos_r[k_r] <= fpu_rsp.res;
            end else begin
              vel_r[k_r] <= fpu_rsp.res;
            end
            if (k_r == 2'd2) begin
              k_r <= '0;
              if (!pos_phase_r && item_r.end_of_message) begin
                pos_phase_r <= 1'b1;
                state_r     <= S_MUL;
              end else begin
                state_r <= S_EMIT;
              end
            end else begin
              k_r     <= k_r + 2'd1;
              state_r <= S_MUL;
            end
          end
        end
        S_EMIT: begin
          if (!out_valid_r || out_s.ready) begin
            out_data_r.packet_found <= found_r;
            out_data_r.accel_x      <= accel_r[0];
            out_data_r.accel_y      <= accel_r[1];
            out_data_r.accel_z      <= accel_r[2];
            out_data_r.vel_x        <= vel_r[0];
            out_data_r.vel_y        <= vel_r[1];
            out_data_r.vel_z        <= vel_r[2];
            out_data_r.pos_x        <= pos_r[0];
            out_data_r.pos_y        <= pos_r[1];
            out_data_r.pos_z        <= pos_r[2];
            out_valid_r             <= 1'b1;
            state_r                 <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_s.ready    = rst_n && (state_r == S_IDLE);
  assign out_s.valid   = out_valid_r;
  assign out_s.payload = out_data_r;

endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
// Self-checking testbench for the IMU packet sync integrator.
`timescale 1ns / 1ps

module testbench;

  localparam int CycleLimit  = 400000;
  localparam int SettleCycles = 100;
  localparam int ItemsPerPhase = 52;

  typedef struct {
    imu_pkg::imu_item_t   item;
    bit                   typed;
    imu_pkg::imu_result_t snap;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [imu_pkg::CfgIdxW-1:0] cfg_index;
  logic [31:0] cfg_data;

  imu_item_if   in_if();
  imu_result_if out_if();

  imu_packet_sync_integrator_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_s      (in_if),
    .out_s     (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow of the block's registers and state
  logic [31:0] sh_step;
  logic [7:0]  sh_hdr [3];
  logic [7:0]  sh_win [imu_pkg::WinDepth];
  int          sh_fill;
  logic [31:0] sh_acc [3];
  logic [31:0] sh_vel [3];
  logic [31:0] sh_pos [3];

  imu_pkg::imu_result_t pending_snapshots[$];
  int cycle_count;
  int mismatches;
  int results_seen;
  int packets_seen;
  int items_sent;
  int burst_left;
  int rdy_left;
  bit rdy_val;

  // Round a value m * 2^e to single precision, nearest even, with subnormals
  function automatic logic [31:0] fp_round(input logic sgn, input logic [127:0] m,
                                           input int e);
    int p;
    int sh;
    int k;
    logic [127:0] q;
    logic [127:0] rem;
    logic [127:0] half;
    if (m == 0) return {sgn, 31'd0};
    p = 0;
    for (int i = 0; i < 128; i++) if (m[i]) p = i;
    sh = p - 23;
    if (sh < -149 - e) sh = -149 - e;
    if (sh <= 0) begin
      q = m << (-sh);
    end else if (sh > 120) begin
      q = '0;
    end else begin
      q = m >> sh;
      rem = m & ((128'd1 << sh) - 1);
      half = 128'd1 << (sh - 1);
      if (rem > half || (rem == half && q[0])) q = q + 1;
    end
    k = e + sh;
    if (q[24]) begin
      q = q >> 1;
      k++;
    end
    if (q < 128'h80_0000) return {sgn, 8'd0, q[22:0]};
    if (k + 150 >= 255) return {sgn, 8'hFF, 23'd0};
    return {sgn, 8'(k + 150), q[22:0]};
  endfunction

  function automatic bit fp_is_nan(input logic [31:0] a);
    return a[30:23] == 8'hFF && a[22:0] != 0;
  endfunction

  function automatic bit fp_is_inf(input logic [31:0] a);
    return a[30:23] == 8'hFF && a[22:0] == 0;
  endfunction

  function automatic logic [127:0] fp_sig(input logic [31:0] a);
    return (a[30:23] == 0) ? 128'(a[22:0]) : 128'({1'b1, a[22:0]});
  endfunction

  function automatic int fp_exp(input logic [31:0] a);
    return (a[30:23] == 0) ? -149 : int'(a[30:23]) - 150;
  endfunction

  function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
    logic s;
    s = a[31] ^ b[31];
    if (fp_is_nan(a) || fp_is_nan(b)) return imu_pkg::CANON_NAN;
    if (fp_is_inf(a) || fp_is_inf(b)) begin
      if (a[30:0] == 0 || b[30:0] == 0) return imu_pkg::CANON_NAN;
      return {s, 8'hFF, 23'd0};
    end
    return fp_round(s, fp_sig(a) * fp_sig(b), fp_exp(a) + fp_exp(b));
  endfunction

  function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] hi;
    logic [31:0] lo;
    logic [127:0] mh;
    logic [127:0] ml;
    int d;
    int e;
    if (fp_is_nan(a) || fp_is_nan(b)) return imu_pkg::CANON_NAN;
    if (fp_is_inf(a) && fp_is_inf(b) && a[31] != b[31]) return imu_pkg::CANON_NAN;
    if (fp_is_inf(a)) return a;
    if (fp_is_inf(b)) return b;
    hi = a;
    lo = b;
    if (fp_exp(b) > fp_exp(a)) begin
      hi = b;
      lo = a;
    end
    mh = fp_sig(hi);
    ml = fp_sig(lo);
    d = fp_exp(hi) - fp_exp(lo);
    // collapse a far smaller operand into a sticky bit
    if (d > 54) begin
      mh = mh << 30;
      ml = (ml != 0) ? 128'd1 : 128'd0;
      e = fp_exp(hi) - 30;
    end else begin
      mh = mh << d;
      e = fp_exp(lo);
    end
    if (hi[31] == lo[31]) return fp_round(hi[31], mh + ml, e);
    if (mh > ml) return fp_round(hi[31], mh - ml, e);
    if (ml > mh) return fp_round(lo[31], ml - mh, e);
    return 32'd0;
  endfunction

  function automatic logic [31:0] mac_step(input logic [31:0] acc, input logic [31:0] val);
    return fp_add(acc, fp_mul(val, sh_step));
  endfunction

  // Advance the shadow state by one item and return the expected snapshot
  function automatic imu_pkg::imu_result_t integrate_item(input imu_pkg::imu_item_t it);
    imu_pkg::imu_result_t r;
    r = '0;
    if (it.byte_valid) begin
      if (sh_fill >= imu_pkg::WinDepth && sh_win[0] == sh_hdr[0] &&
          sh_win[1] == sh_hdr[1] && sh_win[2] == sh_hdr[2]) begin
        r.packet_found = 1'b1;
        sh_acc[0] = {sh_win[3], sh_win[4], sh_win[5], sh_win[6]};
        sh_acc[1] = {sh_win[7], sh_win[8], sh_win[9], sh_win[10]};
        sh_acc[2] = {sh_win[11], sh_win[12], sh_win[13], it.data_byte};
        for (int k = 0; k < 3; k++) sh_vel[k] = mac_step(sh_vel[k], sh_acc[k]);
      end
      if (sh_fill < imu_pkg::WinDepth) begin
        sh_win[sh_fill] = it.data_byte;
        sh_fill++;
      end else begin
        for (int k = 0; k < imu_pkg::WinDepth - 1; k++) sh_win[k] = sh_win[k + 1];
        sh_win[imu_pkg::WinDepth - 1] = it.data_byte;
      end
    end
    if (it.end_of_message) begin
      for (int k = 0; k < 3; k++) sh_pos[k] = mac_step(sh_pos[k], sh_vel[k]);
      for (int k = 0; k < imu_pkg::WinDepth; k++) sh_win[k] = 8'd0;
      sh_fill = 0;
    end
    {r.accel_x, r.accel_y, r.accel_z} = {sh_acc[0], sh_acc[1], sh_acc[2]};
    {r.vel_x, r.vel_y, r.vel_z} = {sh_vel[0], sh_vel[1], sh_vel[2]};
    {r.pos_x, r.pos_y, r.pos_z} = {sh_pos[0], sh_pos[1], sh_pos[2]};
    return r;
  endfunction

  function automatic imu_pkg::imu_item_t mk_item(input logic v, input logic [7:0] b,
                                                 input logic eom);
    imu_pkg::imu_item_t it;
    it.byte_valid = v;
    it.data_byte = b;
    it.end_of_message = eom;
    return it;
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Timeout guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               pending_snapshots.size());
      $display("testbench failed");
      $finish;
    end
  end

  // Receiver: stall on a pattern of random stretches
  always @(negedge clk) begin
    if (rdy_left == 0) begin
      rdy_val = ($urandom_range(0, 3) != 0);
      rdy_left = rdy_val ? $urandom_range(1, 30) : $urandom_range(1, 12);
    end
    rdy_left--;
    out_if.ready <= rdy_val;
  end

  // Compare each result transfer against the oldest pending snapshot
  always @(posedge clk) begin
    imu_pkg::imu_result_t want;
    imu_pkg::imu_result_t got;
    logic [31:0] wf [10];
    logic [31:0] gf [10];
    if (rst_n && out_if.valid && out_if.ready) begin
      got = out_if.payload;
      results_seen++;
      if (got.packet_found) packets_seen++;
      if (pending_snapshots.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer at cycle %0d", cycle_count);
      end else begin
        want = pending_snapshots.pop_front();
        wf = '{32'(want.packet_found), want.accel_x, want.accel_y, want.accel_z, want.vel_x,
               want.vel_y, want.vel_z, want.pos_x, want.pos_y, want.pos_z};
        gf = '{32'(got.packet_found), got.accel_x, got.accel_y, got.accel_z, got.vel_x,
               got.vel_y, got.vel_z, got.pos_x, got.pos_y, got.pos_z};
        for (int k = 0; k < 10; k++) begin
          if (wf[k] !== gf[k]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d field %0d: expected %h, got %h", results_seen, k,
                       wf[k], gf[k]);
          end
        end
      end
    end
  end

  // Drive one item in bursts with random gaps; called at a falling edge
  task automatic send_item(input imu_pkg::imu_item_t it, input bit typed,
                           input imu_pkg::imu_result_t snap);
    imu_pkg::imu_result_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        in_if.valid <= 1'b0;
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end
    end
    burst_left--;
    in_if.valid <= 1'b1;
    in_if.payload <= it;
    do @(posedge clk); while (!in_if.ready);
    r = integrate_item(it);
    pending_snapshots.push_back(typed ? snap : r);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_byte(input logic v, input logic [7:0] b, input logic eom);
    send_item(mk_item(v, b, eom), 1'b0, '0);
  endtask

  // Occasionally slip an ignored item into a sequence
  task automatic maybe_noise();
    if ($urandom_range(0, 9) == 0) send_byte(1'b0, 8'($urandom), 1'b0);
  endtask

  function automatic logic [31:0] rand_accel();
    logic s;
    s = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 15))
      0: return {s, 31'd0};
      1: return {s, 8'hFF, 23'd0};
      2: return {s, 8'hFF, 23'($urandom_range(1, 32'h7F_FFFF))};
      3: return {s, 8'd0, 23'($urandom)};
      4: return {s, 31'h7F7F_FFFF};
      5: return $urandom;
      default: return {s, 8'($urandom_range(115, 135)), 23'($urandom)};
    endcase
  endfunction

  // Header plus three big-endian accelerations
  task automatic send_packet(input bit eom_last);
    logic [95:0] body;
    for (int k = 0; k < 3; k++) begin
      send_byte(1'b1, sh_hdr[k], 1'b0);
      maybe_noise();
    end
    body = {rand_accel(), rand_accel(), rand_accel()};
    for (int k = 11; k >= 0; k--) begin
      send_byte(1'b1, body[k*8 +: 8], (k == 0) && eom_last);
      if (k != 0) maybe_noise();
    end
  endtask

  task automatic send_message();
    int kind;
    int npk;
    bit eom_last;
    kind = $urandom_range(0, 9);
    repeat ($urandom_range(0, 3)) send_byte(1'b1, 8'($urandom), 1'b0);
    eom_last = 1'b0;
    if (kind < 7) begin
      npk = $urandom_range(1, 2);
      for (int p = 0; p < npk; p++) begin
        eom_last = (p == npk - 1) && ($urandom_range(0, 2) == 0);
        send_packet(eom_last);
      end
    end else if (kind == 7) begin
      // corrupted header, then a full payload
      npk = $urandom_range(0, 2);
      for (int k = 0; k < 3; k++) send_byte(1'b1, (k == npk) ? ~sh_hdr[k] : sh_hdr[k], 1'b0);
      repeat (12) send_byte(1'b1, 8'($urandom), 1'b0);
    end else if (kind == 8) begin
      // truncated packet
      for (int k = 0; k < 3; k++) send_byte(1'b1, sh_hdr[k], 1'b0);
      repeat ($urandom_range(0, 11)) send_byte(1'b1, 8'($urandom), 1'b0);
    end else begin
      repeat ($urandom_range(1, 20)) send_byte(1'b1, 8'($urandom), 1'b0);
    end
    if (!eom_last) begin
      if ($urandom_range(0, 1)) send_byte(1'b0, 8'($urandom), 1'b1);
      else send_byte(1'b1, 8'($urandom), 1'b1);
    end
  endtask

  // Hold until every pending result has arrived and the block is quiet
  task automatic settle();
    in_if.valid <= 1'b0;
    while (pending_snapshots.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_reg(input logic [imu_pkg::CfgIdxW-1:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      imu_pkg::CFG_TIME_STEP:     sh_step = val;
      imu_pkg::CFG_HEADER_FIRST:  sh_hdr[0] = val[7:0];
      imu_pkg::CFG_HEADER_SECOND: sh_hdr[1] = val[7:0];
      imu_pkg::CFG_HEADER_THIRD:  sh_hdr[2] = val[7:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic load_setting(input logic [31:0] step, input logic [7:0] h0,
                              input logic [7:0] h1, input logic [7:0] h2);
    write_reg(imu_pkg::CFG_TIME_STEP, step);
    write_reg(imu_pkg::CFG_HEADER_FIRST, 32'(h0));
    write_reg(imu_pkg::CFG_HEADER_SECOND, 32'(h1));
    write_reg(imu_pkg::CFG_HEADER_THIRD, 32'(h2));
    cfg_we <= 1'b0;
  endtask

  dir_row_t             dir_rows[$];
  imu_pkg::imu_result_t zero_snap;
  imu_pkg::imu_result_t pkt_snap;
  logic [7:0]           pkt_bytes [15];
  logic [31:0]          step_set [7];
  int                   target;

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.payload = '0;
    out_if.ready = 1'b0;
    cycle_count = 0;
    mismatches = 0;
    results_seen = 0;
    packets_seen = 0;
    items_sent = 0;
    burst_left = 0;
    rdy_left = 0;
    rdy_val = 1'b0;
    sh_step = imu_pkg::TIME_STEP_RST;
    sh_hdr = '{imu_pkg::HDR_FIRST_RST, imu_pkg::HDR_SECOND_RST, imu_pkg::HDR_THIRD_RST};
    sh_fill = 0;
    for (int k = 0; k < imu_pkg::WinDepth; k++) sh_win[k] = 8'd0;
    for (int k = 0; k < 3; k++) begin
      sh_acc[k] = '0;
      sh_vel[k] = '0;
      sh_pos[k] = '0;
    end

    // Directed rows: idle and empty end after reset, one known packet, edge bytes
    zero_snap = '0;
    pkt_snap = '0;
    pkt_snap.packet_found = 1'b1;
    pkt_snap.accel_x = 32'h3F80_0000;
    pkt_snap.accel_z = 32'hBF80_0000;
    pkt_snap.vel_x = 32'h3CCC_CCCD;
    pkt_snap.vel_z = 32'hBCCC_CCCD;
    pkt_bytes = '{8'h40, 8'h30, 8'h0C, 8'h3F, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00,
                  8'h00, 8'h00, 8'hBF, 8'h80, 8'h00, 8'h00};
    dir_rows.push_back('{mk_item(1'b0, 8'hFF, 1'b0), 1'b1, zero_snap});
    dir_rows.push_back('{mk_item(1'b0, 8'h00, 1'b1), 1'b1, zero_snap});
    for (int k = 0; k < 15; k++)
      dir_rows.push_back('{mk_item(1'b1, pkt_bytes[k], 1'b0), k == 14, pkt_snap});
    dir_rows.push_back('{mk_item(1'b0, 8'h00, 1'b1), 1'b0, zero_snap});
    dir_rows.push_back('{mk_item(1'b1, 8'hFF, 1'b1), 1'b0, zero_snap});
    dir_rows.push_back('{mk_item(1'b1, 8'h00, 1'b0), 1'b0, zero_snap});
    dir_rows.push_back('{mk_item(1'b0, 8'hAA, 1'b1), 1'b0, zero_snap});

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].snap);

    // Random phases over default, extreme and random settings
    step_set = '{imu_pkg::TIME_STEP_RST, 32'h3F80_0000, 32'h0000_0001, 32'h7F7F_FFFF,
                 {1'b0, 8'($urandom_range(100, 126)), 23'($urandom)}, 32'hFFFF_FFFF,
                 32'h0000_0000};
    for (int ph = 0; ph < 7; ph++) begin
      if (ph != 0) begin
        settle();
        case (ph)
          1: load_setting(step_set[ph], 8'h00, 8'hFF, 8'h00);
          2: load_setting(step_set[ph], 8'hFF, 8'hFF, 8'hFF);
          6: load_setting(step_set[ph], imu_pkg::HDR_FIRST_RST, imu_pkg::HDR_SECOND_RST,
                          imu_pkg::HDR_THIRD_RST);
          default: load_setting(step_set[ph], 8'($urandom), 8'($urandom), 8'($urandom));
        endcase
        @(negedge clk);
      end
      target = items_sent + ItemsPerPhase;
      while (items_sent < target) send_message();
    end

    in_if.valid <= 1'b0;
    while (pending_snapshots.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);

    $display("covered %0d items and %0d result transfers over 7 register settings",
             items_sent, results_seen);
    $display("%0d packets found, %0d mismatches", packets_seen, mismatches);
    if (mismatches == 0 && pending_snapshots.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
